/* src/pns_pkg.sv */
// ----------------------------------------------------------------------------
// pns_pkg
// Shared types and constants of the slew-rate FIR stimulation monitor.
// ----------------------------------------------------------------------------
package pns_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SLEW_W   = 17;
  localparam int COEF_W   = 16;
  localparam int CIDX_W   = 6;
  localparam int OUT_W    = 40;
  localparam int CFG_W    = 7;
  localparam int PROD_W   = SLEW_W + COEF_W + 1;

  localparam logic [CFG_W-1:0] ACTIVE_TAPS_RST = 7'd64;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEFF  = 1'b1;

  typedef struct packed {
    logic                       operation;
    logic                       first;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CIDX_W-1:0]          coeff_index;
    logic [COEF_W-1:0]          coeff_value;
  } in_word_t;

  typedef struct packed {
    logic                    valid_res;
    logic signed [OUT_W-1:0] pns_value;
    logic [OUT_W-1:0]        peak_pns;
  } out_word_t;

  typedef struct packed {
    logic              shift;
    logic              rot;
    logic              clr;
    logic              wr;
    logic [CIDX_W-1:0] wr_idx;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
  } mac_ctrl_t;

endpackage

/* src/pns_cell.sv */
// ----------------------------------------------------------------------------
// pns_cell
// One tap of the ring: holds a slew and its kernel weight, shifts new slews
// in from the left and rotates both toward tap zero during accumulation.
// ----------------------------------------------------------------------------
module pns_cell #(
  parameter int IDX = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pns_pkg::cell_ctrl_t                 ctrl,
  input  logic [pns_pkg::COEF_W-1:0]          coef_in,
  input  logic signed [pns_pkg::SLEW_W-1:0]   shift_in,
  input  logic signed [pns_pkg::SLEW_W-1:0]   rot_slew_in,
  input  logic [pns_pkg::COEF_W-1:0]          rot_coef_in,
  output logic signed [pns_pkg::SLEW_W-1:0]   slew_o,
  output logic [pns_pkg::COEF_W-1:0]          coef_o
);
  import pns_pkg::*;

  logic signed [SLEW_W-1:0] slew_r, slew_nxt;
  logic [COEF_W-1:0]        coef_r, coef_nxt;
  logic                     sel;

  assign sel = ctrl.wr && (int'(ctrl.wr_idx) == IDX);

  always_comb begin
    slew_nxt = slew_r;
    coef_nxt = coef_r;
    if (ctrl.clr) begin
      slew_nxt = '0;
    end else if (ctrl.shift) begin
      slew_nxt = shift_in;
    end else if (ctrl.rot) begin
      slew_nxt = rot_slew_in;
      coef_nxt = rot_coef_in;
    end
    if (sel) begin
      coef_nxt = coef_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slew_r <= '0;
      coef_r <= '0;
    end else begin
      slew_r <= slew_nxt;
      coef_r <= coef_nxt;
    end
  end

  assign slew_o = slew_r;
  assign coef_o = coef_r;

endmodule

/* src/pns_mac.sv */
// ----------------------------------------------------------------------------
// pns_mac
// Registered multiply of the tap at the head of the ring, accumulation,
// and saturation of the sum to the output width.
// ----------------------------------------------------------------------------
module pns_mac #(
  parameter int TAPS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pns_pkg::mac_ctrl_t                 ctrl,
  input  logic signed [pns_pkg::SLEW_W-1:0]  slew_i,
  input  logic [pns_pkg::COEF_W-1:0]         coef_i,
  output logic signed [pns_pkg::OUT_W-1:0]   sum_o
);
  import pns_pkg::*;

  localparam int ACC_W = PROD_W + $clog2(TAPS);
  localparam int EXT_W = (ACC_W > OUT_W) ? ACC_W : OUT_W + 1;
  localparam logic signed [EXT_W-1:0] SUM_MAX =
    {{(EXT_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [EXT_W-1:0] SUM_MIN =
    {{(EXT_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_en_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [EXT_W-1:0]  acc_ext, sat;

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (prod_en_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_en_r <= 1'b0;
    end else begin
      prod_en_r <= ctrl.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(slew_i) * PROD_W'($signed({1'b0, coef_i}));
    acc_r  <= acc_nxt;
  end

  assign acc_ext = EXT_W'(acc_r);

  always_comb begin
    if (acc_ext > SUM_MAX) begin
      sat = SUM_MAX;
    end else if (acc_ext < SUM_MIN) begin
      sat = SUM_MIN;
    end else begin
      sat = acc_ext;
    end
  end

  assign sum_o = sat[OUT_W-1:0];

endmodule

/* src/pns_slew_fir_monitor.sv */
// ----------------------------------------------------------------------------
// pns_slew_fir_monitor
// Slew-rate FIR monitor: differences gradient samples, filters the slews
// through a ring of tap cells with one shared multiply-accumulate, and keeps
// the running peak magnitude of the filtered value.
// ----------------------------------------------------------------------------
// path: a filtered sample passes S_MAC (the tap ring rotating once past the
//   single multiplier), S_FLUSH, S_FIN and S_WAIT; other words go to S_WAIT
// flow: S_WAIT holds until the output slot is free; a new word is taken only
//   in S_IDLE, so not before the previous result is handed off
// reset: synchronous active-low rst_n clears history, kernel, peak and
//   sets active_taps to 64; no clearing pass is needed
module pns_slew_fir_monitor #(
  parameter int TAPS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  pns_pkg::in_word_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pns_pkg::out_word_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pns_pkg::CFG_W-1:0]   cfg_data
);
  import pns_pkg::*;

  localparam int IDXW = $clog2(TAPS);
  localparam int CNTW = $clog2(TAPS + 1);
  localparam int N_W  = (CNTW > CFG_W) ? CNTW : CFG_W;

  typedef enum logic [2:0] {S_IDLE, S_MAC, S_FLUSH, S_FIN, S_WAIT} state_t;

  state_t                     state_r, state_nxt;
  logic [IDXW-1:0]            cnt_r, cnt_nxt;
  logic signed [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic                       have_prev_r, have_prev_nxt;
  logic [OUT_W-1:0]           peak_r, peak_nxt;
  out_word_t                  res_r, res_nxt;
  out_word_t                  out_data_r, out_data_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [CFG_W-1:0]           taps_r, taps_nxt;

  logic                       in_acc, is_sample, run;
  logic [N_W-1:0]             taps_ext, n_used;
  logic signed [SLEW_W-1:0]   new_slew;
  logic signed [OUT_W-1:0]    sum;
  logic [OUT_W-1:0]           mag;
  cell_ctrl_t                 cctrl;
  mac_ctrl_t                  mctrl;

  logic signed [SLEW_W-1:0]   slew_w [TAPS];
  logic [COEF_W-1:0]          coef_w [TAPS];
  logic signed [SLEW_W-1:0]   shift_w [TAPS];

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign is_sample = (in_data.operation == OP_SAMPLE);
  assign run       = in_acc && is_sample && !in_data.first && have_prev_r;
  assign new_slew  = SLEW_W'(in_data.sample) - SLEW_W'(prev_r);

  assign taps_ext = N_W'(taps_r);
  always_comb begin
    if (taps_r == '0) begin
      n_used = N_W'(1);
    end else if (taps_ext > N_W'(TAPS)) begin
      n_used = N_W'(TAPS);
    end else begin
      n_used = taps_ext;
    end
  end

  always_comb begin
    cctrl.shift  = run;
    cctrl.rot    = (state_r == S_MAC);
    cctrl.clr    = in_acc && is_sample && in_data.first;
    cctrl.wr     = in_acc && (in_data.operation == OP_COEFF);
    cctrl.wr_idx = in_data.coeff_index;
    mctrl.clear  = run;
    mctrl.mul_en = (state_r == S_MAC) && (N_W'(cnt_r) < n_used);
  end

  for (genvar k = 0; k < TAPS; k++) begin : g_tap
    if (k == 0) begin : g_head
      assign shift_w[k] = new_slew;
    end else begin : g_body
      assign shift_w[k] = slew_w[k-1];
    end
    pns_cell #(.IDX(k)) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (cctrl),
      .coef_in     (in_data.coeff_value),
      .shift_in    (shift_w[k]),
      .rot_slew_in (slew_w[(k + 1) % TAPS]),
      .rot_coef_in (coef_w[(k + 1) % TAPS]),
      .slew_o      (slew_w[k]),
      .coef_o      (coef_w[k])
    );
  end

  pns_mac #(.TAPS(TAPS)) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mctrl),
    .slew_i (slew_w[0]),
    .coef_i (coef_w[0]),
    .sum_o  (sum)
  );

  assign mag = sum[OUT_W-1] ? (~sum + 1'b1) : sum;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    peak_nxt      = peak_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    taps_nxt      = cfg_valid ? cfg_data : taps_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (run) begin
            prev_nxt  = in_data.sample;
            cnt_nxt   = '0;
            state_nxt = S_MAC;
          end else begin
            if (is_sample) begin
              prev_nxt      = in_data.sample;
              have_prev_nxt = 1'b1;
              if (in_data.first) begin
                peak_nxt = '0;
              end
            end
            res_nxt.valid_res = 1'b0;
            res_nxt.pns_value = '0;
            res_nxt.peak_pns  = (is_sample && in_data.first) ? '0 : peak_r;
            state_nxt         = S_WAIT;
          end
        end
      end
      S_MAC: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == IDXW'(TAPS - 1)) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        peak_nxt          = (mag > peak_r) ? mag : peak_r;
        res_nxt.valid_res = 1'b1;
        res_nxt.pns_value = sum;
        res_nxt.peak_pns  = (mag > peak_r) ? mag : peak_r;
        state_nxt         = S_WAIT;
      end
      S_WAIT: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
      taps_r      <= ACTIVE_TAPS_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      peak_r      <= peak_nxt;
      out_valid_r <= out_valid_nxt;
      taps_r      <= taps_nxt;
    end
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  logic [OUT_W-1:0] out_mag;
  assign out_mag = out_data_r.pns_value[OUT_W-1] ?
                   (~out_data_r.pns_value + 1'b1) : out_data_r.pns_value;

  a_run_starts_ring: assert property (@(posedge clk) disable iff (!rst_n)
    run |=> (state_r == S_MAC) && (cnt_r == '0))
    else $error("filtered word did not start the tap ring at tap zero");

  a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !cctrl.clr |=> peak_r >= $past(peak_r))
    else $error("peak dropped without a new waveform");

  a_out_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_WAIT)
    else $error("result word appeared outside the handoff state");

  a_peak_covers_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.valid_res |-> out_data_r.peak_pns >= out_mag)
    else $error("peak below magnitude of its own filtered value");

endmodule
